/* rtl/tt_pkg.sv */
// ----------------------------------------------------------------------------
// tt_pkg
// Shared constants, codes and controller/datapath handshake types for the
// timer table with tick planner.
// ----------------------------------------------------------------------------
package tt_pkg;

	localparam int TIMER_SLOTS_DEF = 16;

	localparam logic [33:0] TICK_LIMIT = 34'd2147483647;

	typedef enum logic [1:0] {
		CMD_START   = 2'd0,
		CMD_STOP    = 2'd1,
		CMD_PROCESS = 2'd2,
		CMD_PURGE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_PURGED = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		RD_IDX  = 2'd0,
		RD_LAST = 2'd1,
		RD_PLAN = 2'd2
	} rsel_t;

	typedef struct packed {
		logic  in_ready;
		logic  idx_clr;
		logic  idx_inc;
		logic  idx_dec;
		logic  idx_load_used;
		rsel_t rsel;
		logic  wr_entry;
		logic  copy_last;
		logic  touch;
		logic  set_replaced;
		logic  set_rejected;
		logic  plan_init;
		logic  plan_step;
		logic  pidx_clr;
		logic  gcd_first;
		logic  gcd_load;
		logic  gcd_step;
		logic  gcd_store;
		logic  plan_commit;
		logic  emit;
		kind_t emit_kind;
	} ctl_cmd_t;

	typedef struct packed {
		logic take;
		cmd_t cmd;
		logic found;
		logic idx_lt_used;
		logic idx_zero;
		logic full;
		logic due;
		logic one_shot;
		logic script;
		logic pidx_lt_used;
		logic all_rep;
		logic used_zero;
		logic gcd_done;
		logic out_free;
	} dp_stat_t;

endpackage

/* rtl/tt_in_if.sv */
// ----------------------------------------------------------------------------
// tt_in_if
// Command channel: valid/ready handshake with one command beat.
// ----------------------------------------------------------------------------
interface tt_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] timer_id;
	logic [30:0] period;
	logic        repeats;
	logic [31:0] now_ms;

	modport source (output valid, command, timer_id, period, repeats, now_ms, input ready);
	modport sink   (input valid, command, timer_id, period, repeats, now_ms, output ready);
endinterface

/* rtl/tt_out_if.sv */
// ----------------------------------------------------------------------------
// tt_out_if
// Event channel: valid/ready handshake with one event or status beat.
// ----------------------------------------------------------------------------
interface tt_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] event_id;
	logic        was_one_shot;
	logic [30:0] tick_ms;
	logic        tick_changed;
	logic        rejected;
	logic        replaced;
	logic        last;

	modport source (output valid, kind, event_id, was_one_shot, tick_ms, tick_changed,
		rejected, replaced, last, input ready);
	modport sink   (input valid, kind, event_id, was_one_shot, tick_ms, tick_changed,
		rejected, replaced, last, output ready);
endinterface

/* rtl/tt_datapath.sv */
// ----------------------------------------------------------------------------
// tt_datapath
// Timer table registers, scan counters, tick planner (minimum and binary GCD)
// and the output beat register.
// ----------------------------------------------------------------------------
module tt_datapath #(
	parameter int TIMER_SLOTS = tt_pkg::TIMER_SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	tt_in_if.sink            cmd_in,
	tt_out_if.source         evt_out,
	input  tt_pkg::ctl_cmd_t ctl,
	output tt_pkg::dp_stat_t stat
);
	localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CW = $clog2(TIMER_SLOTS + 1);

	logic [31:0] id_mem_q   [TIMER_SLOTS];
	logic [30:0] per_mem_q  [TIMER_SLOTS];
	logic [31:0] last_mem_q [TIMER_SLOTS];
	logic        rep_mem_q  [TIMER_SLOTS];

	logic [1:0]  cmd_q;
	logic [31:0] id_q;
	logic [30:0] period_q;
	logic        repeats_q;
	logic [31:0] now_q;

	logic [CW-1:0] used_q, idx_q, pidx_q, used_m1;
	logic [30:0]   planned_q, acc_q, ga_q, gb_q;
	logic [4:0]    shift_q;
	logic [33:0]   best_q;
	logic          all_rep_q, moved_q, replaced_q, rejected_q;

	logic          out_valid_q;
	logic [1:0]    out_kind_q;
	logic [31:0]   out_id_q;
	logic          out_one_q;
	logic [30:0]   out_tick_q;
	logic          out_changed_q, out_rej_q, out_rep_q;

	logic [IW-1:0] rd_addr, wr_addr;
	logic [31:0]   rd_id, rd_last, elapsed;
	logic [30:0]   rd_per, gcd_res, new_tick;
	logic          rd_rep, take, out_free, emit_status;
	logic [33:0]   diff;

	assign used_m1 = used_q - CW'(1);
	assign wr_addr = idx_q[IW-1:0];

	always_comb begin
		case (ctl.rsel)
			tt_pkg::RD_LAST: rd_addr = used_m1[IW-1:0];
			tt_pkg::RD_PLAN: rd_addr = pidx_q[IW-1:0];
			default:         rd_addr = idx_q[IW-1:0];
		endcase
	end

	assign rd_id   = id_mem_q[rd_addr];
	assign rd_per  = per_mem_q[rd_addr];
	assign rd_last = last_mem_q[rd_addr];
	assign rd_rep  = rep_mem_q[rd_addr];
	assign elapsed = now_q - rd_last;
	assign diff    = {3'b000, rd_per} - {2'b00, elapsed};
	assign gcd_res = (ga_q | gb_q) << shift_q;

	always_comb begin
		if (used_q == '0) begin
			new_tick = '0;
		end else if (all_rep_q) begin
			new_tick = (acc_q == '0) ? 31'd1 : acc_q;
		end else if ($signed(best_q) < 34'sd1) begin
			new_tick = 31'd1;
		end else begin
			new_tick = best_q[30:0];
		end
	end

	assign take     = cmd_in.valid && ctl.in_ready;
	assign out_free = !out_valid_q || evt_out.ready;
	assign cmd_in.ready = ctl.in_ready;
	assign emit_status  = (ctl.emit_kind == tt_pkg::KIND_STATUS);

	always_comb begin
		stat.take         = take;
		stat.cmd          = tt_pkg::cmd_t'(cmd_q);
		stat.found        = (rd_id == id_q);
		stat.idx_lt_used  = (idx_q < used_q);
		stat.idx_zero     = (idx_q == '0);
		stat.full         = (used_q >= CW'(TIMER_SLOTS));
		stat.due          = (elapsed >= {1'b0, rd_per});
		stat.one_shot     = !rd_rep;
		stat.script       = !rd_id[31];
		stat.pidx_lt_used = (pidx_q < used_q);
		stat.all_rep      = all_rep_q;
		stat.used_zero    = (used_q == '0);
		stat.gcd_done     = (ga_q == '0) || (gb_q == '0);
		stat.out_free     = out_free;
	end

	// table contents: no reset, entries beyond the fill count are never read
	always_ff @(posedge clk) begin
		if (ctl.wr_entry) begin
			id_mem_q[wr_addr]   <= id_q;
			per_mem_q[wr_addr]  <= period_q;
			last_mem_q[wr_addr] <= now_q;
			rep_mem_q[wr_addr]  <= repeats_q;
		end else if (ctl.copy_last) begin
			id_mem_q[wr_addr]   <= rd_id;
			per_mem_q[wr_addr]  <= rd_per;
			last_mem_q[wr_addr] <= rd_last;
			rep_mem_q[wr_addr]  <= rd_rep;
		end else if (ctl.touch) begin
			last_mem_q[wr_addr] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q     <= cmd_in.command;
			id_q      <= cmd_in.timer_id;
			period_q  <= cmd_in.period;
			repeats_q <= cmd_in.repeats;
			now_q     <= cmd_in.now_ms;
		end
		if (ctl.plan_init) begin
			best_q <= tt_pkg::TICK_LIMIT;
		end else if (ctl.plan_step && ($signed(diff) < $signed(best_q))) begin
			best_q <= diff;
		end
		if (ctl.gcd_first) begin
			acc_q <= rd_per;
		end else if (ctl.gcd_store) begin
			acc_q <= gcd_res;
		end
		if (ctl.gcd_load) begin
			ga_q    <= acc_q;
			gb_q    <= rd_per;
			shift_q <= '0;
		end else if (ctl.gcd_step) begin
			// one binary GCD step: halve even operands, subtract when both odd
			if (!ga_q[0] && !gb_q[0]) begin
				ga_q    <= ga_q >> 1;
				gb_q    <= gb_q >> 1;
				shift_q <= shift_q + 5'd1;
			end else if (!ga_q[0]) begin
				ga_q <= ga_q >> 1;
			end else if (!gb_q[0]) begin
				gb_q <= gb_q >> 1;
			end else if (ga_q > gb_q) begin
				ga_q <= ga_q - gb_q;
			end else begin
				gb_q <= gb_q - ga_q;
			end
		end
		if (ctl.emit) begin
			out_kind_q    <= ctl.emit_kind;
			out_id_q      <= emit_status ? 32'd0 : rd_id;
			out_one_q     <= (ctl.emit_kind == tt_pkg::KIND_FIRED) && !rd_rep;
			// hold the status fields with the beat while the next command runs
			out_tick_q    <= emit_status ? planned_q : 31'd0;
			out_changed_q <= emit_status && moved_q;
			out_rej_q     <= emit_status && rejected_q;
			out_rep_q     <= emit_status && replaced_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			idx_q       <= '0;
			pidx_q      <= '0;
			planned_q   <= '0;
			all_rep_q   <= 1'b1;
			moved_q     <= 1'b0;
			replaced_q  <= 1'b0;
			rejected_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				moved_q    <= 1'b0;
				replaced_q <= 1'b0;
				rejected_q <= 1'b0;
			end
			if (ctl.set_replaced) replaced_q <= 1'b1;
			if (ctl.set_rejected) rejected_q <= 1'b1;

			if (ctl.idx_clr) begin
				idx_q <= '0;
			end else if (ctl.idx_load_used) begin
				idx_q <= used_q;
			end else if (ctl.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end else if (ctl.idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end

			if (ctl.wr_entry && !replaced_q) begin
				used_q <= used_q + CW'(1);
			end else if (ctl.copy_last) begin
				used_q <= used_m1;
			end

			if (ctl.plan_init || ctl.pidx_clr) begin
				pidx_q <= '0;
			end else if (ctl.plan_step || ctl.gcd_first || ctl.gcd_store) begin
				pidx_q <= pidx_q + CW'(1);
			end

			if (ctl.plan_init) begin
				all_rep_q <= 1'b1;
			end else if (ctl.plan_step && !rd_rep) begin
				all_rep_q <= 1'b0;
			end

			if (ctl.plan_commit && (new_tick != planned_q)) begin
				planned_q <= new_tick;
				moved_q   <= 1'b1;
			end

			if (ctl.emit) begin
				out_valid_q <= 1'b1;
			end else if (evt_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign evt_out.valid        = out_valid_q;
	assign evt_out.kind         = out_kind_q;
	assign evt_out.event_id     = out_id_q;
	assign evt_out.was_one_shot = out_one_q;
	assign evt_out.tick_ms      = out_tick_q;
	assign evt_out.tick_changed = out_changed_q;
	assign evt_out.rejected     = out_rej_q;
	assign evt_out.replaced     = out_rep_q;
	assign evt_out.last         = (out_kind_q == tt_pkg::KIND_STATUS);

endmodule

/* rtl/tt_ctrl.sv */
// ----------------------------------------------------------------------------
// tt_ctrl
// Sequencer: walks the table for each command, runs the tick planner and
// pushes event and status beats.
// ----------------------------------------------------------------------------
module tt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  tt_pkg::dp_stat_t stat,
	output tt_pkg::ctl_cmd_t ctl
);
	typedef enum logic [17:0] {
		ST_IDLE       = 18'h00001,
		ST_DISPATCH   = 18'h00002,
		ST_FIND       = 18'h00004,
		ST_START_WR   = 18'h00008,
		ST_PROC_RD    = 18'h00010,
		ST_PROC_EMIT  = 18'h00020,
		ST_DROP_CP    = 18'h00040,
		ST_PURGE_RD   = 18'h00080,
		ST_PURGE_CHK  = 18'h00100,
		ST_PURGE_EMIT = 18'h00200,
		ST_PURGE_CP   = 18'h00400,
		ST_PLAN_INIT  = 18'h00800,
		ST_PLAN_SCAN  = 18'h01000,
		ST_GCD_FIRST  = 18'h02000,
		ST_GCD_LOAD   = 18'h04000,
		ST_GCD_RUN    = 18'h08000,
		ST_PLAN_DONE  = 18'h10000,
		ST_STATUS     = 18'h20000
	} state_t;

	state_t state_q, state_d;
	logic   ret_proc_q, ret_proc_d;

	always_comb begin
		state_d    = state_q;
		ret_proc_d = ret_proc_q;
		ctl        = '0;
		ctl.rsel   = tt_pkg::RD_IDX;
		ctl.emit_kind = tt_pkg::KIND_STATUS;
		case (state_q)
			ST_IDLE: begin
				ctl.in_ready = 1'b1;
				if (stat.take) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				ret_proc_d = (stat.cmd == tt_pkg::CMD_PROCESS);
				case (stat.cmd)
					tt_pkg::CMD_START, tt_pkg::CMD_STOP: begin
						ctl.idx_clr = 1'b1;
						state_d = ST_FIND;
					end
					tt_pkg::CMD_PROCESS: begin
						ctl.idx_clr = 1'b1;
						state_d = ST_PROC_RD;
					end
					default: begin
						ctl.idx_load_used = 1'b1;
						state_d = ST_PURGE_RD;
					end
				endcase
			end
			ST_FIND: begin
				if (!stat.idx_lt_used) begin
					if (stat.cmd == tt_pkg::CMD_STOP) begin
						state_d = ST_STATUS;
					end else if (stat.full) begin
						ctl.set_rejected = 1'b1;
						state_d = ST_STATUS;
					end else begin
						ctl.idx_load_used = 1'b1;
						state_d = ST_START_WR;
					end
				end else if (stat.found) begin
					if (stat.cmd == tt_pkg::CMD_STOP) begin
						state_d = ST_DROP_CP;
					end else begin
						ctl.set_replaced = 1'b1;
						state_d = ST_START_WR;
					end
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			ST_START_WR: begin
				ctl.wr_entry = 1'b1;
				state_d = ST_PLAN_INIT;
			end
			ST_PROC_RD: begin
				if (!stat.idx_lt_used) begin
					state_d = ST_STATUS;
				end else if (stat.due) begin
					state_d = ST_PROC_EMIT;
				end else begin
					ctl.idx_inc = 1'b1;
				end
			end
			ST_PROC_EMIT: begin
				if (stat.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = tt_pkg::KIND_FIRED;
					if (stat.one_shot) begin
						state_d = ST_DROP_CP;
					end else begin
						ctl.touch   = 1'b1;
						ctl.idx_inc = 1'b1;
						state_d = ST_PROC_RD;
					end
				end
			end
			ST_DROP_CP: begin
				ctl.rsel      = tt_pkg::RD_LAST;
				ctl.copy_last = 1'b1;
				state_d = ST_PLAN_INIT;
			end
			ST_PURGE_RD: begin
				if (stat.idx_zero) begin
					state_d = ST_PLAN_INIT;
				end else begin
					ctl.idx_dec = 1'b1;
					state_d = ST_PURGE_CHK;
				end
			end
			ST_PURGE_CHK: begin
				state_d = stat.script ? ST_PURGE_EMIT : ST_PURGE_RD;
			end
			ST_PURGE_EMIT: begin
				if (stat.out_free) begin
					ctl.emit      = 1'b1;
					ctl.emit_kind = tt_pkg::KIND_PURGED;
					state_d = ST_PURGE_CP;
				end
			end
			ST_PURGE_CP: begin
				ctl.rsel      = tt_pkg::RD_LAST;
				ctl.copy_last = 1'b1;
				state_d = ST_PURGE_RD;
			end
			ST_PLAN_INIT: begin
				ctl.plan_init = 1'b1;
				state_d = ST_PLAN_SCAN;
			end
			ST_PLAN_SCAN: begin
				ctl.rsel = tt_pkg::RD_PLAN;
				if (stat.pidx_lt_used) begin
					ctl.plan_step = 1'b1;
				end else if (stat.used_zero || !stat.all_rep) begin
					state_d = ST_PLAN_DONE;
				end else begin
					ctl.pidx_clr = 1'b1;
					state_d = ST_GCD_FIRST;
				end
			end
			ST_GCD_FIRST: begin
				ctl.rsel      = tt_pkg::RD_PLAN;
				ctl.gcd_first = 1'b1;
				state_d = ST_GCD_LOAD;
			end
			ST_GCD_LOAD: begin
				ctl.rsel = tt_pkg::RD_PLAN;
				if (stat.pidx_lt_used) begin
					ctl.gcd_load = 1'b1;
					state_d = ST_GCD_RUN;
				end else begin
					state_d = ST_PLAN_DONE;
				end
			end
			ST_GCD_RUN: begin
				if (stat.gcd_done) begin
					ctl.gcd_store = 1'b1;
					state_d = ST_GCD_LOAD;
				end else begin
					ctl.gcd_step = 1'b1;
				end
			end
			ST_PLAN_DONE: begin
				ctl.plan_commit = 1'b1;
				state_d = ret_proc_q ? ST_PROC_RD : ST_STATUS;
			end
			ST_STATUS: begin
				if (stat.out_free) begin
					ctl.emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ret_proc_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			ret_proc_q <= ret_proc_d;
		end
	end

endmodule

/* rtl/timer_table_with_tick_planner_top.sv */
// ----------------------------------------------------------------------------
// timer_table_with_tick_planner_top
// Timer table with tick planner: start, stop, process and purge commands over
// a table of timers, with replanning of the tick delay after each change.
// ----------------------------------------------------------------------------
// Sequence: each command walks the table slot by slot, then, after each table change, the
//   tick delay is replanned over the timers in use; with only repeating timers each
//   further timer adds a binary GCD. Output stalls lengthen a command.
// Throughput: one command at a time; the next beat is taken the cycle after the status
//   beat has been loaded into the output register.
// Reset: arst_n clears fill count, planned tick and control; table contents stay unread.
module timer_table_with_tick_planner_top #(
	parameter int TIMER_SLOTS = tt_pkg::TIMER_SLOTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	tt_in_if.sink    cmd_in,
	tt_out_if.source evt_out
);
	tt_pkg::ctl_cmd_t ctl;
	tt_pkg::dp_stat_t stat;

	// sequencer: decides which slot to read, write or drop each cycle
	tt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// table, planner arithmetic and the output beat register
	tt_datapath #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_in  (cmd_in),
		.evt_out (evt_out),
		.ctl     (ctl),
		.stat    (stat)
	);

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, stop, process and purge commands into the timer table, plus
// random traffic, with random gaps on both channels. Every beat coming out
// is compared field by field against a local model of the table and the
// tick planner.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SLOTS = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] event_id;
		logic        was_one_shot;
		logic [30:0] tick_ms;
		logic        tick_changed;
		logic        rejected;
		logic        replaced;
		logic        last;
	} beat_t;

	typedef struct {
		tt_pkg::cmd_t cmd;
		logic [31:0] id;
		logic [30:0] period;
		logic        repeats;
		logic [31:0] now;
		bit          typed;
		logic [30:0] want_tick;
		logic        want_rej;
	} row_t;

	logic clk;
	logic arst_n;
	tt_in_if  cmd_in ();
	tt_out_if evt_out ();

	timer_table_with_tick_planner_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_in(cmd_in),
		.evt_out(evt_out)
	);

	// Local copy of the timer table and planner state.
	logic [31:0] tbl_id [SLOTS];
	logic [30:0] tbl_period [SLOTS];
	logic [31:0] tbl_last [SLOTS];
	logic        tbl_rep [SLOTS];
	int          tbl_used;
	logic [30:0] tick_plan;
	bit          tick_moved;

	beat_t pending_beats[$];
	int    error_count;
	int    idle_cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int ctz(logic [31:0] v);
		int n;
		n = 0;
		while (n < 31 && !v[n]) n++;
		return n;
	endfunction

	function automatic logic [31:0] binary_gcd(logic [31:0] a, logic [31:0] b);
		int sh;
		logic [31:0] t;
		if (a == 0) return b;
		if (b == 0) return a;
		sh = ctz(a | b);
		a = a >> ctz(a);
		do begin
			b = b >> ctz(b);
			if (a > b) begin
				t = a;
				a = b;
				b = t;
			end
			b = b - a;
		end while (b != 0);
		return a << sh;
	endfunction

	function automatic void plan_tick(logic [31:0] now);
		logic [31:0] nt;
		longint best, d;
		bit all_rep;
		all_rep = 1;
		for (int i = 0; i < tbl_used; i++) if (!tbl_rep[i]) all_rep = 0;
		if (tbl_used == 0) begin
			nt = 0;
		end else if (all_rep) begin
			nt = {1'b0, tbl_period[0]};
			for (int i = 1; i < tbl_used; i++) nt = binary_gcd(nt, {1'b0, tbl_period[i]});
			if (nt < 1) nt = 1;
		end else begin
			best = 64'sd2147483647;
			for (int i = 0; i < tbl_used; i++) begin
				d = longint'({1'b0, tbl_period[i]}) - longint'({32'd0, now - tbl_last[i]});
				if (d < best) best = d;
			end
			if (best < 1) best = 1;
			nt = best[31:0];
		end
		if (nt[30:0] != tick_plan) begin
			tick_plan = nt[30:0];
			tick_moved = 1;
		end
	endfunction

	function automatic void drop_entry(int idx);
		tbl_used--;
		if (idx != tbl_used) begin
			tbl_id[idx] = tbl_id[tbl_used];
			tbl_period[idx] = tbl_period[tbl_used];
			tbl_last[idx] = tbl_last[tbl_used];
			tbl_rep[idx] = tbl_rep[tbl_used];
		end
	endfunction

	function automatic int find_entry(logic [31:0] id);
		for (int i = 0; i < tbl_used; i++) if (tbl_id[i] == id) return i;
		return -1;
	endfunction

	function automatic beat_t make_beat(tt_pkg::kind_t k, logic [31:0] id, logic one);
		beat_t b;
		b = '0;
		b.kind = k;
		b.event_id = id;
		b.was_one_shot = one;
		return b;
	endfunction

	// Advance the table by one command and queue the beats it must produce.
	function automatic beat_t apply_command(row_t r);
		int idx;
		int i;
		bit rej, rep;
		beat_t st;
		rej = 0;
		rep = 0;
		tick_moved = 0;
		case (r.cmd)
			tt_pkg::CMD_START: begin
				idx = find_entry(r.id);
				if (idx < 0) begin
					if (tbl_used >= SLOTS) rej = 1;
					else begin
						idx = tbl_used;
						tbl_used++;
						tbl_id[idx] = r.id;
					end
				end else rep = 1;
				if (!rej) begin
					tbl_rep[idx] = r.repeats;
					tbl_last[idx] = r.now;
					tbl_period[idx] = r.period;
					plan_tick(r.now);
				end
			end
			tt_pkg::CMD_STOP: begin
				idx = find_entry(r.id);
				if (idx >= 0) begin
					drop_entry(idx);
					plan_tick(r.now);
				end
			end
			tt_pkg::CMD_PROCESS: begin
				i = 0;
				while (i < tbl_used) begin
					if (r.now - tbl_last[i] >= {1'b0, tbl_period[i]}) begin
						pending_beats.push_back(make_beat(tt_pkg::KIND_FIRED, tbl_id[i],
							!tbl_rep[i]));
						tbl_last[i] = r.now;
						if (!tbl_rep[i]) begin
							drop_entry(i);
							plan_tick(r.now);
							continue;
						end
					end
					i++;
				end
			end
			default: begin
				for (i = tbl_used - 1; i >= 0; i--) begin
					if (!tbl_id[i][31]) begin
						pending_beats.push_back(make_beat(tt_pkg::KIND_PURGED, tbl_id[i], 1'b0));
						drop_entry(i);
					end
				end
				plan_tick(r.now);
			end
		endcase
		st = make_beat(tt_pkg::KIND_STATUS, 32'd0, 1'b0);
		st.tick_ms = tick_plan;
		st.tick_changed = tick_moved;
		st.rejected = rej;
		st.replaced = rep;
		st.last = 1'b1;
		pending_beats.push_back(st);
		return st;
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Directed rows; the typed-in tick and reject flags hold only where obvious.
	row_t directed[$];
	logic [31:0] clock_ms;

	function automatic row_t mk(tt_pkg::cmd_t c, logic [31:0] id, logic [30:0] p, logic rp,
		logic [31:0] now, bit typed = 0, logic [30:0] tk = 0, logic rj = 0);
		row_t r;
		r.cmd = c; r.id = id; r.period = p; r.repeats = rp; r.now = now;
		r.typed = typed; r.want_tick = tk; r.want_rej = rj;
		return r;
	endfunction

	// Valid stays high across back-to-back rows; drop it only ahead of a gap.
	task automatic send_row(row_t r);
		beat_t st;
		int gap;
		st = apply_command(r);
		if (r.typed) begin
			if (st.tick_ms != r.want_tick)
				report_mismatch("typed tick", 64'(st.tick_ms), 64'(r.want_tick));
			if (st.rejected != r.want_rej)
				report_mismatch("typed reject", 64'(st.rejected), 64'(r.want_rej));
		end
		gap = gap_len();
		if (gap > 0) begin
			cmd_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_in.valid <= 1'b1;
		cmd_in.command <= r.cmd;
		cmd_in.timer_id <= r.id;
		cmd_in.period <= r.period;
		cmd_in.repeats <= r.repeats;
		cmd_in.now_ms <= r.now;
		do @(posedge clk); while (!cmd_in.ready);
	endtask

	function automatic row_t random_row();
		row_t r;
		int pick;
		logic [31:0] id;
		pick = $urandom_range(0, 99);
		clock_ms = clock_ms + $urandom_range(0, 60);
		if ($urandom_range(0, 30) == 0) clock_ms = $urandom;
		// Mostly reuse a small id pool so stops and replacements hit.
		if ($urandom_range(0, 4) == 0) id = $urandom;
		else id = 32'($urandom_range(0, 23) - 6);
		r = mk(tt_pkg::CMD_START, id, 31'($urandom_range(1, 80)), 1'($urandom_range(0, 1)),
			clock_ms);
		if ($urandom_range(0, 15) == 0) r.period = 31'($urandom);
		if ($urandom_range(0, 7) == 0)
			r.period = $urandom_range(0, 1) ? 31'd0 : 31'(8 << $urandom_range(0, 3));
		if (pick < 45) r.cmd = tt_pkg::CMD_START;
		else if (pick < 60) r.cmd = tt_pkg::CMD_STOP;
		else if (pick < 95) r.cmd = tt_pkg::CMD_PROCESS;
		else r.cmd = tt_pkg::CMD_PURGE;
		return r;
	endfunction

	// Receiver side: random stalls, compare each beat with the oldest expectation.
	initial begin
		beat_t got, want;
		evt_out.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (evt_out.valid && evt_out.ready) begin
				got.kind = evt_out.kind;
				got.event_id = evt_out.event_id;
				got.was_one_shot = evt_out.was_one_shot;
				got.tick_ms = evt_out.tick_ms;
				got.tick_changed = evt_out.tick_changed;
				got.rejected = evt_out.rejected;
				got.replaced = evt_out.replaced;
				got.last = evt_out.last;
				if (pending_beats.size() == 0) begin
					report_mismatch("unexpected beat", 64'(got.event_id), 64'd0);
				end else begin
					want = pending_beats.pop_front();
					if (got.kind != want.kind)
						report_mismatch("kind", 64'(got.kind), 64'(want.kind));
					if (got.event_id != want.event_id)
						report_mismatch("event_id", 64'(got.event_id), 64'(want.event_id));
					if (got.was_one_shot != want.was_one_shot)
						report_mismatch("was_one_shot", 64'(got.was_one_shot),
							64'(want.was_one_shot));
					if (got.tick_ms != want.tick_ms)
						report_mismatch("tick_ms", 64'(got.tick_ms), 64'(want.tick_ms));
					if (got.tick_changed != want.tick_changed)
						report_mismatch("tick_changed", 64'(got.tick_changed),
							64'(want.tick_changed));
					if (got.rejected != want.rejected)
						report_mismatch("rejected", 64'(got.rejected), 64'(want.rejected));
					if (got.replaced != want.replaced)
						report_mismatch("replaced", 64'(got.replaced), 64'(want.replaced));
					if (got.last != want.last)
						report_mismatch("last", 64'(got.last), 64'(want.last));
				end
			end
			// Random stalls: mostly ready, with ready dropped on a random cycle now and then.
			if ($urandom_range(0, 29) == 0) evt_out.ready <= 1'b0;
			else if ($urandom_range(0, 2) != 0) evt_out.ready <= 1'b1;
			else evt_out.ready <= 1'($urandom_range(0, 1));
		end
	end

	// Watchdog: count cycles with no beat on either channel.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((cmd_in.valid && cmd_in.ready) || (evt_out.valid && evt_out.ready))
				idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	initial begin
		row_t r;
		error_count = 0;
		tbl_used = 0;
		tick_plan = 0;
		clock_ms = 32'd1000;
		cmd_in.valid = 1'b0;
		cmd_in.command = tt_pkg::CMD_START;
		cmd_in.timer_id = '0;
		cmd_in.period = '0;
		cmd_in.repeats = 1'b0;
		cmd_in.now_ms = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table: process and purge leave the tick at zero.
		directed.push_back(mk(tt_pkg::CMD_PROCESS, 0, 0, 0, 32'd0, 1, 31'd0));
		directed.push_back(mk(tt_pkg::CMD_PURGE, 0, 0, 0, 32'd5, 1, 31'd0));
		directed.push_back(mk(tt_pkg::CMD_STOP, 32'h7FFFFFFF, 0, 0, 32'd5, 1, 31'd0));
		// One repeating timer with zero interval: GCD clamps to one.
		directed.push_back(mk(tt_pkg::CMD_START, 32'h80000000, 31'd0, 1, 32'hFFFFFFFF, 1,
			31'd1));
		directed.push_back(mk(tt_pkg::CMD_START, 32'h80000000, 31'h7FFFFFFF, 1, 32'd0, 1,
			31'h7FFFFFFF));
		directed.push_back(mk(tt_pkg::CMD_START, 32'h7FFFFFFF, 31'd24, 1, 32'd0));
		directed.push_back(mk(tt_pkg::CMD_START, 32'd5, 31'd36, 1, 32'd0));
		// One-shot present: planner switches to minimum time left.
		directed.push_back(mk(tt_pkg::CMD_START, 32'hFFFFFFFF, 31'd10, 0, 32'd0));
		directed.push_back(mk(tt_pkg::CMD_PROCESS, 0, 0, 0, 32'd30));
		directed.push_back(mk(tt_pkg::CMD_START, 32'd9, 31'd5, 0, 32'd30));
		directed.push_back(mk(tt_pkg::CMD_PROCESS, 0, 0, 0, 32'd100));
		directed.push_back(mk(tt_pkg::CMD_START, 32'd1, 31'd50, 0, 32'hFFFFFFF0));
		// Wrapped elapsed time across zero.
		directed.push_back(mk(tt_pkg::CMD_PROCESS, 0, 0, 0, 32'd40));
		directed.push_back(mk(tt_pkg::CMD_STOP, 32'd5, 0, 0, 32'd40));
		directed.push_back(mk(tt_pkg::CMD_PURGE, 0, 0, 0, 32'd41));
		for (int i = 0; i < 16; i++)
			directed.push_back(mk(tt_pkg::CMD_START, 32'(100 + i), 31'(7 + i), i[0], 32'd50));
		// Table full: a new id is refused, the same id still replaces.
		directed.push_back(mk(tt_pkg::CMD_START, 32'd999, 31'd3, 0, 32'd50, 1, 31'd0, 1'b1));
		directed.push_back(mk(tt_pkg::CMD_START, 32'd100, 31'd3, 1, 32'd51));
		directed.push_back(mk(tt_pkg::CMD_PROCESS, 0, 0, 0, 32'd200));
		directed.push_back(mk(tt_pkg::CMD_PURGE, 0, 0, 0, 32'd201));

		foreach (directed[k]) begin
			r = directed[k];
			// The full-table row keeps the tick unchanged; read it from the table.
			if (r.typed && r.want_rej) r.want_tick = tick_plan;
			send_row(r);
		end

		// Random part, with an occasional burst of fills to reach a full table.
		for (int n = 0; n < 200; n++) begin
			if ($urandom_range(0, 90) == 0) begin
				for (int j = 0; j < 18; j++) begin
					r = mk(tt_pkg::CMD_START, 32'($urandom_range(200, 260)),
						31'($urandom_range(1, 40)), 1'($urandom_range(0, 1)), clock_ms);
					send_row(r);
				end
			end
			send_row(random_row());
		end
		cmd_in.valid <= 1'b0;

		while (pending_beats.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
